### rtl/bcis_pkg.sv
`default_nettype none
package bcis_pkg;

  localparam int unsigned MEM_BYTES_DEF = 65536;

  // Commands on the input channel.
  localparam logic [1:0] CMD_EXEC = 2'd0;
  localparam logic [1:0] CMD_WR   = 2'd1;
  localparam logic [1:0] CMD_RD   = 2'd2;
  localparam logic [1:0] CMD_VEC  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_DIV0 = 2'd3;

  // Kinds of memory access sequence.
  localparam logic [3:0] K_FETCH = 4'd0;
  localparam logic [3:0] K_WR    = 4'd1;
  localparam logic [3:0] K_RD    = 4'd2;
  localparam logic [3:0] K_VEC   = 4'd3;
  localparam logic [3:0] K_LDB   = 4'd4;
  localparam logic [3:0] K_LDW   = 4'd5;
  localparam logic [3:0] K_STB   = 4'd6;
  localparam logic [3:0] K_STW   = 4'd7;
  localparam logic [3:0] K_DUMP  = 4'd8;
  localparam logic [3:0] K_FILL  = 4'd9;

  // Opcodes.
  localparam logic [7:0] OP_AND_RR = 8'h00;
  localparam logic [7:0] OP_AND_RI = 8'h01;
  localparam logic [7:0] OP_OR_RR  = 8'h02;
  localparam logic [7:0] OP_OR_RI  = 8'h03;
  localparam logic [7:0] OP_NOT    = 8'h04;
  localparam logic [7:0] OP_SHL_RR = 8'h05;
  localparam logic [7:0] OP_SHL_RI = 8'h06;
  localparam logic [7:0] OP_SHR_RR = 8'h07;
  localparam logic [7:0] OP_SHR_RI = 8'h08;
  localparam logic [7:0] OP_ADD_RR = 8'h10;
  localparam logic [7:0] OP_ADD_RI = 8'h11;
  localparam logic [7:0] OP_SUB_RR = 8'h12;
  localparam logic [7:0] OP_SUB_RI = 8'h13;
  localparam logic [7:0] OP_RSB    = 8'h14;
  localparam logic [7:0] OP_MUL_RR = 8'h15;
  localparam logic [7:0] OP_MUL_RI = 8'h16;
  localparam logic [7:0] OP_DIV_R  = 8'h17;
  localparam logic [7:0] OP_DIV_I  = 8'h18;
  localparam logic [7:0] OP_MOD_R  = 8'h19;
  localparam logic [7:0] OP_MOD_I  = 8'h1A;
  localparam logic [7:0] OP_MOV    = 8'h20;
  localparam logic [7:0] OP_MOVI   = 8'h21;
  localparam logic [7:0] OP_LDI16  = 8'h22;
  localparam logic [7:0] OP_LDB    = 8'h23;
  localparam logic [7:0] OP_LDW    = 8'h24;
  localparam logic [7:0] OP_STB    = 8'h25;
  localparam logic [7:0] OP_STW    = 8'h26;
  localparam logic [7:0] OP_DUMP   = 8'h27;
  localparam logic [7:0] OP_FILL   = 8'h28;
  localparam logic [7:0] OP_CMP    = 8'h30;
  localparam logic [7:0] OP_TST_R  = 8'h31;
  localparam logic [7:0] OP_TST_I  = 8'h32;
  localparam logic [7:0] OP_SKZ    = 8'h40;
  localparam logic [7:0] OP_SKNZ   = 8'h41;
  localparam logic [7:0] OP_NOP    = 8'hF0;
  localparam logic [7:0] OP_HALT   = 8'hFF;

  // Register file places.
  localparam logic [3:0] R_FLAGS = 4'd0;
  localparam logic [3:0] R_ACC   = 4'd6;
  localparam logic [3:0] R_SI    = 4'd8;
  localparam logic [3:0] R_DI    = 4'd10;
  localparam logic [3:0] R_IP    = 4'd12;
  localparam logic [3:0] R_SP    = 4'd14;
  localparam logic [4:0] PAIR_MOVE_MIN = 5'd14;
  localparam int unsigned ZF_BIT = 1;

  function automatic logic [7:0] shl8(input logic [7:0] x, input logic [7:0] n);
    logic [7:0] res;
    res = (n >= 8'd8) ? 8'd0 : 8'(x << n[2:0]);
    return res;
  endfunction

  function automatic logic [7:0] shr8(input logic [7:0] x, input logic [7:0] n);
    logic [7:0] res;
    res = (n >= 8'd8) ? 8'd0 : 8'(x >> n[2:0]);
    return res;
  endfunction

endpackage
`default_nettype wire

### rtl/byte_cpu_instruction_step_top.sv
// Instruction step unit of a small 8-bit CPU with a 16-byte register file and
// a byte memory. An item on the input channel (in_valid/in_ready) carries a
// command: execute one instruction at the instruction pointer, write a memory
// byte, read a memory byte, or load the instruction pointer from a vector.
// Each item produces exactly one result item on the output channel
// (out_valid/out_ready) with the status, the byte read, the instruction
// pointer, the flags byte and the 16-bit accumulator pair.
// One item is handled at a time; in_ready is high only while the unit idles.
// Every memory byte read passes through address wrap, access and read data
// steps and a write through address wrap and access; divide and modulo use
// the shared restoring divider that produces one quotient bit per cycle.
// Reset clears the register file and the control; memory contents are
// undefined until written. A result waits in the output stage for as long
// as the receiver holds out_ready low, and no new item is taken meanwhile.
`default_nettype none
module byte_cpu_instruction_step_top #(
  parameter int unsigned MEM_BYTES = bcis_pkg::MEM_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [15:0] in_addr,
  input  wire logic [7:0]  in_wdata,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [7:0]       out_rdata,
  output logic [15:0]      out_pc,
  output logic [7:0]       out_flag_byte,
  output logic [15:0]      out_pair_value
);
  import bcis_pkg::*;

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam logic [32:0] RECIP_FULL =
    33'((64'h1_0000_0000 + 64'(MEM_BYTES) - 64'd1) / 64'(MEM_BYTES));
  localparam logic [24:0] RECIP = RECIP_FULL[24:0];
  localparam logic [16:0] MEM_SZ = 17'(MEM_BYTES);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_QUO  = 4'd1;
  localparam logic [3:0] S_MEM  = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_X1   = 4'd4;
  localparam logic [3:0] S_X2   = 4'd5;
  localparam logic [3:0] S_X3   = 4'd6;
  localparam logic [3:0] S_EX   = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_DWB  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]  state_r;
  logic [3:0]  kind_r;
  logic [3:0]  cnt_r;
  logic [3:0]  last_r;
  logic [15:0] base_r;
  logic [8:0]  q_r;
  logic [7:0]  op_r, a1_r, a2_r;
  logic [7:0]  x_r, y_r, z_r;
  logic [7:0]  buf_r;
  logic [7:0]  wdata_r;
  logic [7:0]  rdata_r;
  logic [1:0]  status_r;
  logic [15:0] quo_r;
  logic [7:0]  rem_r;
  logic [7:0]  regs_r [16];

  logic [3:0]  hi, lo, rr;
  logic [15:0] addr_cur;
  logic [40:0] prod;
  logic [16:0] wrapped;
  logic        ram_we;
  logic [7:0]  ram_wdata;
  logic [7:0]  ram_q;
  logic [3:0]  rd_idx;
  logic [7:0]  rd_byte;
  logic        mem_last;
  logic [3:0]  after_mem;
  logic [15:0] acc;
  logic [15:0] ip;
  logic [8:0]  div_t;
  logic        div_ge;
  logic [1:0]  ip_inc;
  logic [7:0]  tst_rr, tst_ri;
  logic [3:0]  ex_state_nxt;

  assign hi  = a1_r[7:4];
  assign lo  = a1_r[3:0];
  assign rr  = a2_r[3:0];
  assign acc = {regs_r[R_ACC + 4'd1], regs_r[R_ACC]};
  assign ip  = {regs_r[R_IP + 4'd1], regs_r[R_IP]};

  assign tst_rr = shr8(y_r, y_r);
  assign tst_ri = shr8(y_r, a2_r);

  // Address wrap modulo the memory size: quotient by reciprocal, then remainder.
  assign addr_cur = base_r + 16'(cnt_r);
  assign prod     = 41'(addr_cur) * 41'(RECIP);
  assign wrapped  = {1'b0, addr_cur} - 17'({8'd0, q_r} * MEM_SZ);

  always_comb begin
    case (kind_r)
      K_WR:    ram_we = 1'b1;
      K_STB:   ram_we = 1'b1;
      K_STW:   ram_we = 1'b1;
      K_DUMP:  ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
    ram_we = ram_we && (state_r == S_MEM);
  end

  always_comb begin
    case (kind_r)
      K_WR:    ram_wdata = wdata_r;
      K_STB:   ram_wdata = y_r;
      K_STW:   ram_wdata = (cnt_r == 4'd0) ? acc[7:0] : acc[15:8];
      K_DUMP:  ram_wdata = rd_byte;
      default: ram_wdata = 8'd0;
    endcase
  end

  bcis_ram #(
    .WIDTH(8),
    .DEPTH(MEM_BYTES)
  ) u_mem (
    .clk  (clk),
    .we   (ram_we),
    .addr (wrapped[AW-1:0]),
    .wdata(ram_wdata),
    .rdata(ram_q)
  );

  // Indexed register file read port.
  always_comb begin
    case (state_r)
      S_X2:    rd_idx = lo;
      S_X3:    rd_idx = hi + 4'd1;
      S_MEM:   rd_idx = cnt_r;
      default: rd_idx = hi;
    endcase
  end
  assign rd_byte = regs_r[rd_idx];

  assign mem_last = (cnt_r == last_r);

  always_comb begin
    case (kind_r)
      K_FETCH: after_mem = S_X1;
      K_WR:    after_mem = S_OUT;
      K_RD:    after_mem = S_OUT;
      K_VEC:   after_mem = S_OUT;
      default: after_mem = S_FIN;
    endcase
  end

  // Where the execute cycle goes next for each opcode.
  always_comb begin
    case (op_r)
      OP_DIV_R, OP_MOD_R: ex_state_nxt = (x_r == 8'd0) ? S_OUT : S_DIV;
      OP_DIV_I, OP_MOD_I: ex_state_nxt = (a2_r == 8'd0) ? S_OUT : S_DIV;
      OP_LDB, OP_LDW, OP_FILL, OP_STB, OP_STW, OP_DUMP: ex_state_nxt = S_QUO;
      OP_AND_RR, OP_AND_RI, OP_OR_RR, OP_OR_RI, OP_NOT,
      OP_SHL_RR, OP_SHL_RI, OP_SHR_RR, OP_SHR_RI,
      OP_ADD_RR, OP_ADD_RI, OP_SUB_RR, OP_SUB_RI, OP_RSB,
      OP_MUL_RR, OP_MUL_RI, OP_MOV, OP_MOVI, OP_LDI16,
      OP_CMP, OP_TST_R, OP_TST_I, OP_SKZ, OP_SKNZ, OP_NOP: ex_state_nxt = S_FIN;
      default: ex_state_nxt = S_OUT;
    endcase
  end

  assign div_t  = {rem_r, quo_r[15]};
  assign div_ge = (div_t >= {1'b0, buf_r});

  always_comb begin
    ip_inc = 2'd1;
    if (op_r == OP_SKZ && regs_r[R_FLAGS][ZF_BIT]) begin
      ip_inc = 2'd2;
    end else if (op_r == OP_SKNZ && !regs_r[R_FLAGS][ZF_BIT]) begin
      ip_inc = 2'd2;
    end else if (op_r == OP_MOV && hi == R_IP && lo == R_SP) begin
      ip_inc = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < 16; i++) begin
        regs_r[i] <= 8'd0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            wdata_r  <= in_wdata;
            base_r   <= (in_cmd == CMD_EXEC) ? ip : in_addr;
            cnt_r    <= 4'd0;
            rdata_r  <= 8'd0;
            status_r <= ST_OK;
            state_r  <= S_QUO;
            case (in_cmd)
              CMD_EXEC: begin
                kind_r <= K_FETCH;
                last_r <= 4'd2;
              end
              CMD_WR: begin
                kind_r <= K_WR;
                last_r <= 4'd0;
              end
              CMD_RD: begin
                kind_r <= K_RD;
                last_r <= 4'd0;
              end
              default: begin
                kind_r <= K_VEC;
                last_r <= 4'd1;
              end
            endcase
          end
        end
        S_QUO: begin
          q_r     <= prod[40:32];
          state_r <= S_MEM;
        end
        S_MEM: begin
          if (!ram_we) begin
            state_r <= S_RD;
          end else if (mem_last) begin
            state_r <= after_mem;
          end else begin
            cnt_r   <= cnt_r + 4'd1;
            state_r <= S_QUO;
          end
        end
        S_RD: begin
          case (kind_r)
            K_FETCH: begin
              if (cnt_r == 4'd0) begin
                op_r <= ram_q;
              end else if (cnt_r == 4'd1) begin
                a1_r <= ram_q;
              end else begin
                a2_r <= ram_q;
              end
            end
            K_RD: rdata_r <= ram_q;
            K_VEC: begin
              if (cnt_r == 4'd0) begin
                buf_r <= ram_q;
              end else begin
                {regs_r[R_IP + 4'd1], regs_r[R_IP]} <= {ram_q, buf_r} + 16'd2;
              end
            end
            K_LDB: regs_r[lo] <= ram_q;
            K_LDW: regs_r[R_ACC + cnt_r] <= ram_q;
            K_FILL: regs_r[cnt_r] <= ram_q;
            default: begin
            end
          endcase
          if (mem_last) begin
            state_r <= after_mem;
          end else begin
            cnt_r   <= cnt_r + 4'd1;
            state_r <= S_QUO;
          end
        end
        S_X1: begin
          x_r     <= rd_byte;
          state_r <= S_X2;
        end
        S_X2: begin
          y_r     <= rd_byte;
          state_r <= S_X3;
        end
        S_X3: begin
          z_r     <= rd_byte;
          state_r <= S_EX;
        end
        S_EX: begin
          state_r <= ex_state_nxt;
          cnt_r   <= 4'd0;
          quo_r   <= acc;
          rem_r   <= 8'd0;
          case (op_r)
            OP_AND_RR: regs_r[rr] <= x_r & y_r;
            OP_AND_RI: regs_r[lo] <= x_r & a2_r;
            OP_OR_RR:  regs_r[rr] <= x_r | y_r;
            OP_OR_RI:  regs_r[lo] <= x_r | a2_r;
            OP_NOT:    regs_r[lo] <= ~x_r;
            OP_SHL_RR: regs_r[rr] <= shl8(x_r, y_r);
            OP_SHL_RI: regs_r[lo] <= shl8(x_r, a2_r);
            OP_SHR_RR: regs_r[rr] <= shr8(x_r, y_r);
            OP_SHR_RI: regs_r[lo] <= shr8(x_r, a2_r);
            OP_ADD_RR: regs_r[rr] <= x_r + y_r;
            OP_ADD_RI: regs_r[lo] <= x_r + a2_r;
            OP_SUB_RR: regs_r[rr] <= x_r - y_r;
            OP_SUB_RI: regs_r[lo] <= x_r - a2_r;
            OP_RSB:    regs_r[rr] <= a1_r - x_r;
            OP_MUL_RR: {regs_r[R_ACC + 4'd1], regs_r[R_ACC]} <= x_r * y_r;
            OP_MUL_RI: {regs_r[R_ACC + 4'd1], regs_r[R_ACC]} <= x_r * a2_r;
            OP_DIV_R, OP_MOD_R: begin
              if (x_r == 8'd0) begin
                status_r <= ST_DIV0;
              end else begin
                buf_r <= x_r;
              end
            end
            OP_DIV_I, OP_MOD_I: begin
              if (a2_r == 8'd0) begin
                status_r <= ST_DIV0;
              end else begin
                buf_r <= a2_r;
              end
            end
            OP_MOV: begin
              if (({1'b0, hi} + {1'b0, lo}) >= PAIR_MOVE_MIN) begin
                regs_r[lo]        <= x_r;
                regs_r[lo + 4'd1] <= z_r;
              end else begin
                regs_r[lo] <= x_r;
              end
            end
            OP_MOVI:  regs_r[lo] <= a2_r;
            OP_LDI16: {regs_r[R_ACC + 4'd1], regs_r[R_ACC]} <= {a2_r, a1_r};
            OP_LDB, OP_LDW, OP_FILL: begin
              base_r <= {regs_r[R_SI + 4'd1], regs_r[R_SI]} + 16'd2;
              case (op_r)
                OP_LDB: begin
                  kind_r <= K_LDB;
                  last_r <= 4'd0;
                end
                OP_LDW: begin
                  kind_r <= K_LDW;
                  last_r <= 4'd1;
                end
                default: begin
                  kind_r <= K_FILL;
                  last_r <= 4'd15;
                end
              endcase
            end
            OP_STB, OP_STW, OP_DUMP: begin
              base_r <= {regs_r[R_DI + 4'd1], regs_r[R_DI]} + 16'd2;
              case (op_r)
                OP_STB: begin
                  kind_r <= K_STB;
                  last_r <= 4'd0;
                end
                OP_STW: begin
                  kind_r <= K_STW;
                  last_r <= 4'd1;
                end
                default: begin
                  kind_r <= K_DUMP;
                  last_r <= 4'd15;
                end
              endcase
            end
            OP_CMP:   regs_r[R_FLAGS][ZF_BIT] <= (y_r == x_r);
            OP_TST_R: regs_r[R_FLAGS][ZF_BIT] <= tst_rr[0];
            OP_TST_I: regs_r[R_FLAGS][ZF_BIT] <= tst_ri[0];
            OP_SKZ, OP_SKNZ, OP_NOP: begin
            end
            OP_HALT: begin
              status_r <= ST_HALT;
            end
            default: begin
              status_r <= ST_BAD;
            end
          endcase
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (div_ge) begin
            rem_r <= 8'(div_t - {1'b0, buf_r});
            quo_r <= {quo_r[14:0], 1'b1};
          end else begin
            rem_r <= div_t[7:0];
            quo_r <= {quo_r[14:0], 1'b0};
          end
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            state_r <= S_DWB;
          end
        end
        S_DWB: begin
          case (op_r)
            OP_DIV_R: regs_r[lo] <= quo_r[7:0];
            OP_MOD_R: regs_r[lo] <= rem_r;
            OP_DIV_I: regs_r[hi] <= quo_r[7:0];
            default:  regs_r[hi] <= rem_r;
          endcase
          state_r <= S_FIN;
        end
        S_FIN: begin
          {regs_r[R_IP + 4'd1], regs_r[R_IP]} <= ip + 16'(3 * ip_inc);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = (state_r == S_OUT);
  assign out_status     = status_r;
  assign out_rdata      = rdata_r;
  assign out_pc         = ip;
  assign out_flag_byte  = regs_r[R_FLAGS];
  assign out_pair_value = acc;

endmodule
`default_nettype wire

### rtl/bcis_ram.sv
`default_nettype none
module bcis_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import bcis_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  rdata;
    logic [15:0] pc;
    logic [7:0]  flag_byte;
    logic [15:0] pair_value;
  } step_res_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  op;
    logic [7:0]  a1;
    logic [7:0]  a2;
    bit          typed;
    step_res_t   res;
  } dir_row_t;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_STEPS = 230;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_cmd;
  logic [15:0] in_addr;
  logic [7:0]  in_wdata;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [7:0]  out_rdata;
  logic [15:0] out_pc;
  logic [7:0]  out_flag_byte;
  logic [15:0] out_pair_value;

  byte_cpu_instruction_step_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .in_addr(in_addr), .in_wdata(in_wdata),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_rdata(out_rdata), .out_pc(out_pc),
    .out_flag_byte(out_flag_byte), .out_pair_value(out_pair_value)
  );

  // Shadow copy of the CPU state.
  logic [7:0]  cpu_regs [16];
  logic [7:0]  shadow_mem [0:65535];
  bit          mem_known [0:65535];
  logic [15:0] known_addrs [$];
  step_res_t   pending_results [$];

  logic [7:0] op_list [36] = '{
    OP_AND_RR, OP_AND_RI, OP_OR_RR, OP_OR_RI, OP_NOT, OP_SHL_RR, OP_SHL_RI,
    OP_SHR_RR, OP_SHR_RI, OP_ADD_RR, OP_ADD_RI, OP_SUB_RR, OP_SUB_RI, OP_RSB,
    OP_MUL_RR, OP_MUL_RI, OP_DIV_R, OP_DIV_I, OP_MOD_R, OP_MOD_I, OP_MOV,
    OP_MOVI, OP_LDI16, OP_LDB, OP_LDW, OP_STB, OP_STW, OP_DUMP, OP_FILL,
    OP_CMP, OP_TST_R, OP_TST_I, OP_SKZ, OP_SKNZ, OP_NOP, OP_HALT};

  bit quiet;
  int cycles;
  int n_items, n_exec, n_checked, n_errors;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic logic [15:0] pair_get(input logic [3:0] i);
    return {cpu_regs[i + 4'd1], cpu_regs[i]};
  endfunction

  task automatic pair_set(input logic [3:0] i, input logic [15:0] v);
    cpu_regs[i] = v[7:0];
    cpu_regs[i + 4'd1] = v[15:8];
  endtask

  task automatic mem_put(input logic [15:0] a, input logic [7:0] v);
    shadow_mem[a] = v;
    if (!mem_known[a]) begin
      mem_known[a] = 1'b1;
      known_addrs.push_back(a);
    end
  endtask

  function automatic logic [7:0] shift_left8(input logic [7:0] x, input logic [7:0] n);
    return (n >= 8) ? 8'd0 : 8'(x << n);
  endfunction

  function automatic logic [7:0] shift_right8(input logic [7:0] x, input logic [7:0] n);
    return (n >= 8) ? 8'd0 : 8'(x >> n);
  endfunction

  task automatic set_zero_flag(input bit z);
    cpu_regs[R_FLAGS][ZF_BIT] = z;
  endtask

  task automatic exec_instruction(output logic [1:0] st);
    logic [15:0] ip, acc, base;
    logic [7:0]  op, a1, a2, t;
    logic [3:0]  hi, lo, rr;
    logic [7:0]  tmp [16];
    ip = pair_get(R_IP);
    op = shadow_mem[ip];
    a1 = shadow_mem[ip + 16'd1];
    a2 = shadow_mem[ip + 16'd2];
    hi = a1[7:4];
    lo = a1[3:0];
    rr = a2[3:0];
    acc = pair_get(R_ACC);
    st = ST_OK;
    case (op)
      OP_AND_RR: cpu_regs[rr] = cpu_regs[hi] & cpu_regs[lo];
      OP_AND_RI: cpu_regs[lo] = cpu_regs[hi] & a2;
      OP_OR_RR:  cpu_regs[rr] = cpu_regs[hi] | cpu_regs[lo];
      OP_OR_RI:  cpu_regs[lo] = cpu_regs[hi] | a2;
      OP_NOT:    cpu_regs[lo] = ~cpu_regs[hi];
      OP_SHL_RR: cpu_regs[rr] = shift_left8(cpu_regs[hi], cpu_regs[lo]);
      OP_SHL_RI: cpu_regs[lo] = shift_left8(cpu_regs[hi], a2);
      OP_SHR_RR: cpu_regs[rr] = shift_right8(cpu_regs[hi], cpu_regs[lo]);
      OP_SHR_RI: cpu_regs[lo] = shift_right8(cpu_regs[hi], a2);
      OP_ADD_RR: cpu_regs[rr] = cpu_regs[hi] + cpu_regs[lo];
      OP_ADD_RI: cpu_regs[lo] = cpu_regs[hi] + a2;
      OP_SUB_RR: cpu_regs[rr] = cpu_regs[hi] - cpu_regs[lo];
      OP_SUB_RI: cpu_regs[lo] = cpu_regs[hi] - a2;
      OP_RSB:    cpu_regs[rr] = a1 - cpu_regs[hi];
      OP_MUL_RR: pair_set(R_ACC, 16'(cpu_regs[hi]) * 16'(cpu_regs[lo]));
      OP_MUL_RI: pair_set(R_ACC, 16'(cpu_regs[hi]) * 16'(a2));
      OP_DIV_R: begin
        if (cpu_regs[hi] == 8'd0) st = ST_DIV0;
        else cpu_regs[lo] = 8'(acc / cpu_regs[hi]);
      end
      OP_DIV_I: begin
        if (a2 == 8'd0) st = ST_DIV0;
        else cpu_regs[hi] = 8'(acc / a2);
      end
      OP_MOD_R: begin
        if (cpu_regs[hi] == 8'd0) st = ST_DIV0;
        else cpu_regs[lo] = 8'(acc % cpu_regs[hi]);
      end
      OP_MOD_I: begin
        if (a2 == 8'd0) st = ST_DIV0;
        else cpu_regs[hi] = 8'(acc % a2);
      end
      OP_MOV: begin
        if ({1'b0, hi} + {1'b0, lo} >= PAIR_MOVE_MIN) pair_set(lo, pair_get(hi));
        else cpu_regs[lo] = cpu_regs[hi];
        // Copying RI into RS must leave RI where it was.
        if (lo == R_SP && hi == R_IP) pair_set(R_IP, pair_get(R_IP) - 16'd3);
      end
      OP_MOVI:  cpu_regs[lo] = a2;
      OP_LDI16: pair_set(R_ACC, {a2, a1});
      OP_LDB:   cpu_regs[lo] = shadow_mem[16'(pair_get(R_SI) + 16'd2)];
      OP_LDW: begin
        base = pair_get(R_SI) + 16'd2;
        pair_set(R_ACC, {shadow_mem[16'(base + 16'd1)], shadow_mem[base]});
      end
      OP_STB: mem_put(pair_get(R_DI) + 16'd2, cpu_regs[lo]);
      OP_STW: begin
        base = pair_get(R_DI) + 16'd2;
        mem_put(base, acc[7:0]);
        mem_put(base + 16'd1, acc[15:8]);
      end
      OP_DUMP: begin
        base = pair_get(R_DI) + 16'd2;
        for (int i = 0; i < 16; i++) mem_put(base + 16'(i), cpu_regs[i]);
      end
      OP_FILL: begin
        base = pair_get(R_SI) + 16'd2;
        for (int i = 0; i < 16; i++) tmp[i] = shadow_mem[16'(base + 16'(i))];
        for (int i = 0; i < 16; i++) cpu_regs[i] = tmp[i];
      end
      OP_CMP: set_zero_flag(cpu_regs[lo] == cpu_regs[hi]);
      OP_TST_R: begin
        t = shift_right8(cpu_regs[lo], cpu_regs[lo]);
        set_zero_flag(t[0]);
      end
      OP_TST_I: begin
        t = shift_right8(cpu_regs[lo], a2);
        set_zero_flag(t[0]);
      end
      OP_SKZ:  if (cpu_regs[R_FLAGS][ZF_BIT]) pair_set(R_IP, pair_get(R_IP) + 16'd3);
      OP_SKNZ: if (!cpu_regs[R_FLAGS][ZF_BIT]) pair_set(R_IP, pair_get(R_IP) + 16'd3);
      OP_NOP: ;
      OP_HALT: st = ST_HALT;
      default: st = ST_BAD;
    endcase
    if (st == ST_OK) pair_set(R_IP, pair_get(R_IP) + 16'd3);
  endtask

  task automatic cpu_model_step(input logic [1:0] c, input logic [15:0] a,
                                input logic [7:0] d, output step_res_t r);
    logic [1:0] st;
    logic [7:0] rd;
    st = ST_OK;
    rd = 8'd0;
    case (c)
      CMD_EXEC: exec_instruction(st);
      CMD_WR:   mem_put(a, d);
      CMD_RD:   rd = shadow_mem[a];
      default:  pair_set(R_IP, {shadow_mem[16'(a + 16'd1)], shadow_mem[a]} + 16'd2);
    endcase
    r = '{st, rd, pair_get(R_IP), cpu_regs[R_FLAGS], pair_get(R_ACC)};
  endtask

  // Predicts the item, queues its result and hands it to the block.
  task automatic send_item(input logic [1:0] c, input logic [15:0] a, input logic [7:0] d,
                           input bit typed, input step_res_t typed_res);
    step_res_t r;
    int gap;
    cpu_model_step(c, a, d, r);
    pending_results.push_back(typed ? typed_res : r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_cmd = c;
    in_addr = a;
    in_wdata = d;
    do @(posedge clk); while (!in_ready);
    n_items++;
    if (c == CMD_EXEC) n_exec++;
    // The block stays busy with the item once taken, so dropping valid here costs nothing.
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic need_byte(input logic [15:0] a);
    if (!mem_known[a]) send_item(CMD_WR, a, 8'($urandom), 1'b0, '0);
  endtask

  // Places an instruction at RI if asked, makes sure every byte it reads
  // has been written, then executes it.
  task automatic run_instruction(input bit place, input logic [7:0] op, input logic [7:0] a1,
                                 input logic [7:0] a2, input bit typed,
                                 input step_res_t typed_res);
    logic [15:0] ip, base;
    logic [7:0]  o;
    ip = pair_get(R_IP);
    if (place) begin
      send_item(CMD_WR, ip, op, 1'b0, '0);
      send_item(CMD_WR, ip + 16'd1, a1, 1'b0, '0);
      send_item(CMD_WR, ip + 16'd2, a2, 1'b0, '0);
    end else begin
      need_byte(ip);
      need_byte(ip + 16'd1);
      need_byte(ip + 16'd2);
    end
    o = shadow_mem[ip];
    base = pair_get(R_SI) + 16'd2;
    if (o == OP_LDB) need_byte(base);
    if (o == OP_LDW) begin
      need_byte(base);
      need_byte(base + 16'd1);
    end
    if (o == OP_FILL)
      for (int i = 0; i < 16; i++) need_byte(base + 16'(i));
    send_item(CMD_EXEC, 16'($urandom), 8'($urandom), typed, typed_res);
  endtask

  // Receiver: random stalls while not quiet.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
        @(negedge clk);
      end
      out_ready = 1'b1;
      repeat ($urandom_range(0, 30)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    step_res_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_status, out_rdata, out_pc, out_flag_byte, out_pair_value};
      if (pending_results.size() == 0) begin
        $display("%0t: result item with nothing expected: st=%0d rd=%h pc=%h fl=%h pv=%h",
                 $time, got.status, got.rdata, got.pc, got.flag_byte, got.pair_value);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got !== want) begin
          $display("%0t: mismatch expected st=%0d rd=%h pc=%h fl=%h pv=%h", $time,
                   want.status, want.rdata, want.pc, want.flag_byte, want.pair_value);
          $display("%0t:          actual   st=%0d rd=%h pc=%h fl=%h pv=%h", $time,
                   got.status, got.rdata, got.pc, got.flag_byte, got.pair_value);
          n_errors++;
        end
      end
    end
  end

  initial begin
    dir_row_t rows [$];
    dir_row_t row;
    int pick;
    logic [15:0] a;
    logic [7:0] op, a2;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_EXEC;
    in_addr = 16'd0;
    in_wdata = 8'd0;
    quiet = 1'b0;
    for (int i = 0; i < 16; i++) cpu_regs[i] = 8'd0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    rows.push_back('{CMD_WR, 16'h0010, 8'hA5, 0, 0, 0, 1, '{ST_OK, 8'h00, 16'h0, 8'h0, 16'h0}});
    rows.push_back('{CMD_RD, 16'h0010, 8'h00, 0, 0, 0, 1, '{ST_OK, 8'hA5, 16'h0, 8'h0, 16'h0}});
    rows.push_back('{CMD_WR, 16'hFFFF, 8'h00, 0, 0, 0, 0, '0});
    rows.push_back('{CMD_WR, 16'h0000, 8'h10, 0, 0, 0, 0, '0});
    // The vector word straddles the top of memory and wraps to address zero.
    rows.push_back('{CMD_VEC, 16'hFFFF, 8'hFF, 0, 0, 0, 1, '{ST_OK, 8'h0, 16'h1002, 8'h0, 16'h0}});
    rows.push_back('{CMD_EXEC, 0, 0, OP_HALT, 8'h00, 8'h00, 1, '{ST_HALT, 8'h0, 16'h1002, 8'h0, 16'h0}});
    rows.push_back('{CMD_EXEC, 0, 0, 8'h09, 8'hFF, 8'hFF, 1, '{ST_BAD, 8'h0, 16'h1002, 8'h0, 16'h0}});
    rows.push_back('{CMD_EXEC, 0, 0, OP_DIV_I, 8'h10, 8'h00, 1, '{ST_DIV0, 8'h0, 16'h1002, 8'h0, 16'h0}});
    rows.push_back('{CMD_EXEC, 0, 0, OP_LDI16, 8'hFF, 8'hFF, 1, '{ST_OK, 8'h0, 16'h1005, 8'h0, 16'hFFFF}});
    rows.push_back('{CMD_EXEC, 0, 0, OP_MOVI, 8'h05, 8'hFF, 0, '0});
    rows.push_back('{CMD_EXEC, 0, 0, OP_ADD_RR, 8'h55, 8'h03, 0, '0});
    rows.push_back('{CMD_EXEC, 0, 0, OP_SHL_RI, 8'h53, 8'h08, 0, '0});
    rows.push_back('{CMD_EXEC, 0, 0, OP_SHR_RR, 8'h55, 8'h04, 0, '0});
    rows.push_back('{CMD_EXEC, 0, 0, OP_MUL_RR, 8'h55, 8'h00, 0, '0});
    rows.push_back('{CMD_EXEC, 0, 0, OP_MOD_R, 8'h52, 8'h00, 0, '0});
    rows.push_back('{CMD_EXEC, 0, 0, OP_TST_I, 8'h05, 8'h09, 0, '0});
    rows.push_back('{CMD_EXEC, 0, 0, OP_MOV, 8'hCE, 8'h00, 0, '0});
    rows.push_back('{CMD_EXEC, 0, 0, OP_MOV, 8'hF1, 8'h00, 0, '0});
    rows.push_back('{CMD_EXEC, 0, 0, OP_DUMP, 8'h00, 8'h00, 0, '0});
    rows.push_back('{CMD_EXEC, 0, 0, OP_FILL, 8'h00, 8'h00, 0, '0});

    foreach (rows[i]) begin
      row = rows[i];
      if (row.cmd == CMD_EXEC) run_instruction(1'b1, row.op, row.a1, row.a2, row.typed, row.res);
      else send_item(row.cmd, row.addr, row.wdata, row.typed, row.res);
    end

    for (int step = 0; step < RANDOM_STEPS; step++) begin
      if (step == RANDOM_STEPS * 7 / 8) quiet = 1'b1;
      // Let the block drain completely once mid-run.
      if (step == RANDOM_STEPS / 2)
        while (pending_results.size() != 0) @(posedge clk);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if (step < 36) op = op_list[step];
        else if ($urandom_range(0, 9) == 0) op = 8'($urandom);
        else op = op_list[$urandom_range(0, 35)];
        a2 = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        run_instruction(1'b1, op, 8'($urandom), a2, 1'b0, '0);
      end else if (pick < 78) begin
        run_instruction(1'b0, 8'h00, 8'h00, 8'h00, 1'b0, '0);
      end else if (pick < 88) begin
        a = $urandom_range(0, 1) ? 16'($urandom) : pair_get(R_SI) + 16'($urandom_range(0, 20));
        send_item(CMD_WR, a, 8'($urandom), 1'b0, '0);
      end else if (pick < 95) begin
        a = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
        send_item(CMD_RD, a, 8'($urandom), 1'b0, '0);
      end else begin
        a = $urandom_range(0, 1) ? 16'($urandom)
                                 : known_addrs[$urandom_range(0, known_addrs.size() - 1)];
        need_byte(a);
        need_byte(a + 16'd1);
        send_item(CMD_VEC, a, 8'($urandom), 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Run covered %0d items (%0d instructions) with random stalls on both sides;",
             n_items, n_exec);
    $display("%0d results checked, %0d failures.", n_checked, n_errors);
    if (n_errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
